// ----- hdl/edpc_pkg.sv -----
// Shared types and constants for the edge-disjoint path counter.
// No dependencies; imported by edpc_cap_store, the core top level and the testbench.
`default_nettype none

package edpc_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int NODE_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = NODE_W + 1;

    // Request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_RA,
        ST_ADD_WA,
        ST_ADD_RB,
        ST_ADD_WB,
        ST_COPY,
        ST_INIT,
        ST_POP,
        ST_LOAD,
        ST_SCAN,
        ST_PM_RD,
        ST_PM_CK,
        ST_PM_END,
        ST_PU_RD,
        ST_PU_WU,
        ST_PU_WV,
        ST_DONE
    } state_t;

    // Control from the sequencer to the adjacency store
    typedef struct packed {
        logic                    wr;
        logic                    clr;
        logic [NODE_W-1:0]       addr;
        logic [MAX_VERTICES-1:0] wdata;
    } cap_req_t;

endpackage

`default_nettype wire

// ----- hdl/edpc_cap_store.sv -----
// Adjacency store: one row of edge bits per node, cleared through per-row valid bits.
// Depends on edpc_pkg (cap_req_t, sizes).
`default_nettype none

module edpc_cap_store
    import edpc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cap_req_t                req,
    output logic [MAX_VERTICES-1:0]      rdata
);

    logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic [MAX_VERTICES-1:0] rd_reg;
    logic                    rd_valid_reg;

    // Row valid bits: a cleared row reads as no edges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (req.clr)
        begin
            row_valid_reg <= '0;
        end
        else if (req.wr)
        begin
            row_valid_reg[req.addr] <= 1'b1;
        end
    end

    // Row array, registered read
    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        rd_reg       <= mem[req.addr];
        rd_valid_reg <= row_valid_reg[req.addr] & ~req.clr;
    end

    assign rdata = rd_valid_reg ? rd_reg : '0;

endmodule

`default_nettype wire

// ----- hdl/edge_disjoint_path_counter_core.sv -----
// Top level: edge-disjoint path counter (unit-capacity max flow by BFS).
// Depends on edpc_pkg and edpc_cap_store.
//
//  channel   signals                                   dir  beat
//  request   start, busy, req_type, node_a, node_b     in   start & !busy
//  result    done, path_count, bad_query               out  done (one cycle)
//  config    cfg_we, cfg_wdata                         in   cfg_we
//
// Add edge: read and write of each endpoint's row. Clear, ignored code: handled in idle.
// Bad query: result registered straight from idle. Query: copy into the residual store,
// then per search a seed step, a pop, load and scan for each dequeued node with a scan
// step for each discovered node, then a read and check per path edge for the bottleneck
// and a read and two writes per path edge to augment; all of it through the one-read,
// one-write residual row memory. Reset clears the adjacency row valid bits at once;
// no clearing pass. Results cannot be stalled; busy holds requests off while a request runs.
`default_nettype none

module edge_disjoint_path_counter_core
    import edpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        req_type,
    input  wire logic [NODE_W-1:0] node_a,
    input  wire logic [NODE_W-1:0] node_b,
    input  wire logic              cfg_we,
    input  wire logic [5:0]        cfg_wdata,
    output logic                   done,
    output logic [NODE_W-1:0]      path_count,
    output logic                   bad_query
);

    localparam int ROW_W = 2 * MAX_VERTICES;

    state_t                  state_reg, state_next;
    logic [5:0]              nv_reg;
    logic [CNT_W-1:0]        n_use;
    logic [MAX_VERTICES-1:0] nmask;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NODE_W-1:0]       src_reg, src_next, dst_reg, dst_next;
    logic [CNT_W-1:0]        head_reg, head_next, tail_reg, tail_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] cand_reg, cand_next;
    logic [NODE_W-1:0]       u_reg, u_next, v_reg, v_next;
    logic [CNT_W-1:0]        steps_reg, steps_next;
    logic [1:0]              bn_reg, bn_next;
    logic [NODE_W-1:0]       total_reg, total_next;
    logic                    done_reg, done_next;
    logic [NODE_W-1:0]       count_reg, count_next;
    logic                    bad_reg, bad_next;

    cap_req_t                cap_req;
    logic [MAX_VERTICES-1:0] cap_rdata;

    logic [NODE_W-1:0]       queue_mem  [MAX_VERTICES];
    logic [NODE_W-1:0]       parent_mem [MAX_VERTICES];
    logic                    q_we, p_we;
    logic [NODE_W-1:0]       q_wa, q_wd, p_wa, p_wd;

    logic [ROW_W-1:0]        res_mem [MAX_VERTICES];
    logic [ROW_W-1:0]        res_q;
    logic                    res_we;
    logic [NODE_W-1:0]       res_wa, res_ra;
    logic [ROW_W-1:0]        res_wd;

    logic [MAX_VERTICES-1:0] nz_row;
    logic [NODE_W-1:0]       low_idx;
    logic [1:0]              r_fld;
    logic [2:0]              r_sum;
    logic [CNT_W-1:0]        tot_sum;
    logic                    a_ok, b_ok;

    function automatic logic [NODE_W-1:0] lowest_bit(input logic [MAX_VERTICES-1:0] m);
        logic [NODE_W-1:0] idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = NODE_W'(i);
            end
        end
        return idx;
    endfunction

    edpc_cap_store u_cap (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cap_req),
        .rdata (cap_rdata)
    );

    // Node count in use and its mask
    assign n_use = (nv_reg > 6'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(nv_reg);
    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            nmask[i]      = (CNT_W'(i) < n_use);
            nz_row[i]     = |res_q[2*i +: 2];
        end
    end
    // Adjacency row widened to two-bit residual fields
    logic [ROW_W-1:0] copy_row;
    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            copy_row[2*i +: 2] = {1'b0, cap_rdata[i]};
        end
    end

    assign a_ok    = (CNT_W'(node_a) < n_use);
    assign b_ok    = (CNT_W'(node_b) < n_use);
    assign low_idx = lowest_bit(cand_reg);
    assign r_fld   = res_q[{v_reg, 1'b0} +: 2];
    assign r_sum   = 3'(res_q[{u_reg, 1'b0} +: 2]) + 3'(bn_reg);
    assign tot_sum = CNT_W'(total_reg) + CNT_W'(bn_reg);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= 6'd32;
        end
        else if (cfg_we)
        begin
            nv_reg <= cfg_wdata;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            visited_reg <= '0;
            cand_reg    <= '0;
            steps_reg   <= '0;
            bn_reg      <= '0;
            total_reg   <= '0;
            done_reg    <= 1'b0;
            bad_reg     <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            visited_reg <= visited_next;
            cand_reg    <= cand_next;
            steps_reg   <= steps_next;
            bn_reg      <= bn_next;
            total_reg   <= total_next;
            done_reg    <= done_next;
            bad_reg     <= bad_next;
            count_reg   <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        dst_reg <= dst_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
    end

    // Queue and parent arrays
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_wa] <= q_wd;
        end
        if (p_we)
        begin
            parent_mem[p_wa] <= p_wd;
        end
    end

    // Residual row memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_wa] <= res_wd;
        end
        res_q <= res_mem[res_ra];
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        visited_next = visited_reg;
        cand_next    = cand_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        steps_next   = steps_reg;
        bn_next      = bn_reg;
        total_next   = total_reg;
        done_next    = 1'b0;
        bad_next     = 1'b0;
        count_next   = count_reg;
        cap_req      = '{wr: 1'b0, clr: 1'b0, addr: src_reg, wdata: '0};
        q_we = 1'b0;  q_wa = tail_reg[NODE_W-1:0];  q_wd = low_idx;
        p_we = 1'b0;  p_wa = low_idx;               p_wd = u_reg;
        res_we = 1'b0;
        res_wa = u_reg;
        res_wd = res_q;
        res_ra = u_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                src_next = node_a;
                dst_next = node_b;
                if (start)
                begin
                    unique case (req_type)
                        REQ_ADD:
                        begin
                            if (a_ok && b_ok)
                            begin
                                state_next = ST_ADD_RA;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            cap_req.clr = 1'b1;
                        end
                        REQ_QUERY:
                        begin
                            if (!a_ok || !b_ok || node_a == node_b)
                            begin
                                done_next  = 1'b1;
                                bad_next   = 1'b1;
                                count_next = '0;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                total_next = '0;
                                state_next = ST_COPY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // Edge insert: read-modify-write of both rows
            ST_ADD_RA:
            begin
                cap_req.addr = src_reg;
                state_next   = ST_ADD_WA;
            end
            ST_ADD_WA:
            begin
                cap_req.addr  = src_reg;
                cap_req.wr    = 1'b1;
                cap_req.wdata = cap_rdata | (MAX_VERTICES'(1) << dst_reg);
                state_next    = ST_ADD_RB;
            end
            ST_ADD_RB:
            begin
                cap_req.addr = dst_reg;
                state_next   = ST_ADD_WB;
            end
            ST_ADD_WB:
            begin
                cap_req.addr  = dst_reg;
                cap_req.wr    = 1'b1;
                cap_req.wdata = cap_rdata | (MAX_VERTICES'(1) << src_reg);
                state_next    = ST_IDLE;
            end
            // Copy adjacency rows into the residual store
            ST_COPY:
            begin
                cap_req.addr = cnt_reg[NODE_W-1:0];
                res_wa       = NODE_W'(cnt_reg - 1'b1);
                res_wd       = copy_row;
                res_we       = (cnt_reg != '0);
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAX_VERTICES))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                visited_next = MAX_VERTICES'(1) << src_reg;
                q_we         = 1'b1;
                q_wa         = '0;
                q_wd         = src_reg;
                p_we         = 1'b1;
                p_wa         = src_reg;
                p_wd         = src_reg;
                head_next    = '0;
                tail_next    = CNT_W'(1);
                state_next   = ST_POP;
            end
            ST_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    if (visited_reg[dst_reg])
                    begin
                        v_next     = dst_reg;
                        steps_next = '0;
                        bn_next    = 2'd3;
                        state_next = ST_PM_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    u_next     = queue_mem[head_reg[NODE_W-1:0]];
                    res_ra     = queue_mem[head_reg[NODE_W-1:0]];
                    head_next  = head_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cand_next  = nz_row & ~visited_reg & nmask;
                state_next = ST_SCAN;
            end
            // Discover one neighbor per cycle, lowest node first
            ST_SCAN:
            begin
                if (cand_reg == '0 || tail_reg == CNT_W'(MAX_VERTICES))
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    q_we         = 1'b1;
                    p_we         = 1'b1;
                    tail_next    = tail_reg + 1'b1;
                    visited_next = visited_reg | (MAX_VERTICES'(1) << low_idx);
                    cand_next    = cand_reg & ~(MAX_VERTICES'(1) << low_idx);
                end
            end
            // Walk the parent chain for the bottleneck
            ST_PM_RD:
            begin
                if (v_reg == src_reg || steps_reg >= n_use)
                begin
                    state_next = ST_PM_END;
                end
                else
                begin
                    u_next     = parent_mem[v_reg];
                    res_ra     = parent_mem[v_reg];
                    state_next = ST_PM_CK;
                end
            end
            ST_PM_CK:
            begin
                if (r_fld < bn_reg)
                begin
                    bn_next = r_fld;
                end
                v_next     = u_reg;
                steps_next = steps_reg + 1'b1;
                state_next = ST_PM_RD;
            end
            ST_PM_END:
            begin
                if (bn_reg == 2'd0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    v_next     = dst_reg;
                    steps_next = '0;
                    state_next = ST_PU_RD;
                end
            end
            // Augment: forward minus, reverse plus with saturation
            ST_PU_RD:
            begin
                if (v_reg == src_reg || steps_reg >= n_use)
                begin
                    total_next = (tot_sum > CNT_W'(MAX_VERTICES - 1)) ?
                                 NODE_W'(MAX_VERTICES - 1) : tot_sum[NODE_W-1:0];
                    state_next = ST_INIT;
                end
                else
                begin
                    u_next     = parent_mem[v_reg];
                    res_ra     = parent_mem[v_reg];
                    state_next = ST_PU_WU;
                end
            end
            ST_PU_WU:
            begin
                res_we = 1'b1;
                res_wa = u_reg;
                res_wd = res_q;
                res_wd[{v_reg, 1'b0} +: 2] = r_fld - bn_reg;
                res_ra = v_reg;
                state_next = ST_PU_WV;
            end
            ST_PU_WV:
            begin
                res_we = 1'b1;
                res_wa = v_reg;
                res_wd = res_q;
                res_wd[{u_reg, 1'b0} +: 2] = (r_sum > 3'd3) ? 2'd3 : r_sum[1:0];
                v_next     = u_reg;
                steps_next = steps_reg + 1'b1;
                state_next = ST_PU_RD;
            end
            ST_DONE:
            begin
                done_next  = 1'b1;
                count_next = total_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign path_count = count_reg;
    assign bad_query  = bad_reg;

    // Checks
    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> (head_reg <= tail_reg && tail_reg <= CNT_W'(MAX_VERTICES)))
        else $error("search queue pointers out of order");

    a_cand_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((cand_reg & visited_reg) == '0))
        else $error("candidate node already visited");

    a_src_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP || state_reg == ST_SCAN) |-> visited_reg[src_reg])
        else $error("source not marked visited during search");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && bad_reg) |-> (count_reg == '0 && $past(state_reg) == ST_IDLE))
        else $error("bad query result malformed");

endmodule

`default_nettype wire

// ----- tb/tb_edge_disjoint_path_counter_core.sv -----
// Testbench for edge_disjoint_path_counter_core: request beats are checked against an
// in-bench max-flow predictor on a mirrored adjacency matrix.
// Depends on edpc_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_edge_disjoint_path_counter_core
    import edpc_pkg::*;
();

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        req_type;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              cfg_we;
    logic [5:0]        cfg_wdata;
    logic              done;
    logic [NODE_W-1:0] path_count;
    logic              bad_query;

    typedef struct packed {
        logic [NODE_W-1:0] count;
        logic              bad;
    } flow_result_t;

    // Mirror of the adjacency store and node-count register
    logic [MAX_VERTICES-1:0] adj_mirror [MAX_VERTICES];
    logic [5:0]              node_reg;
    flow_result_t            pending_results [$];
    int                      error_count;
    int                      idle_pct;

    edge_disjoint_path_counter_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .node_a     (node_a),
        .node_b     (node_b),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .path_count (path_count),
        .bad_query  (bad_query)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Unit-capacity Edmonds-Karp on a copy of the adjacency mirror
    function automatic flow_result_t max_flow(int n, int src, int dst);
        logic [1:0]  resid [MAX_VERTICES][MAX_VERTICES];
        int          parent [MAX_VERTICES];
        int          fifo [MAX_VERTICES];
        logic [63:0] seen;
        int          head, tail, u, v, steps, rounds, total, neck, back;
        flow_result_t res;
        res = '0;
        if (src >= n || dst >= n || src == dst)
        begin
            res.bad = 1'b1;
            return res;
        end
        for (int i = 0; i < MAX_VERTICES; i++)
            for (int j = 0; j < MAX_VERTICES; j++)
                resid[i][j] = (i < n && j < n) ? {1'b0, adj_mirror[i][j]} : 2'd0;
        total = 0;
        rounds = 0;
        while (rounds < n * n)
        begin
            head = 0;
            tail = 0;
            seen = 64'd1 << src;
            parent[src] = src;
            fifo[tail++] = src;
            while (head < tail)
            begin
                u = fifo[head++];
                for (v = 0; v < n; v++)
                    if (!seen[v] && resid[u][v] > 0 && tail < MAX_VERTICES)
                    begin
                        fifo[tail++] = v;
                        parent[v] = u;
                        seen[v] = 1'b1;
                    end
            end
            if (!seen[dst])
                break;
            rounds++;
            neck = 3;
            for (v = dst, steps = 0; v != src && steps < n; v = parent[v], steps++)
                if (resid[parent[v]][v] < neck)
                    neck = resid[parent[v]][v];
            if (neck == 0)
                break;
            for (v = dst, steps = 0; v != src && steps < n; v = parent[v], steps++)
            begin
                u = parent[v];
                back = resid[v][u] + neck;
                resid[u][v] = resid[u][v] - neck;
                resid[v][u] = back > 3 ? 2'd3 : back[1:0];
            end
            total += neck;
        end
        res.count = total > 31 ? 5'd31 : total[4:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Send one request beat; update the mirror when accepted.
    // start stays high after the beat; idle gaps and callers drop it.
    task automatic send_request(input logic [1:0] kind, input int a, input int b);
        int n;
        int idle_n;
        idle_n = 0;
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
            idle_n++;
        if (idle_n > 0)
        begin
            start <= 1'b0;
            repeat (idle_n) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= kind;
        node_a   <= a[NODE_W-1:0];
        node_b   <= b[NODE_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n = node_reg > MAX_VERTICES ? MAX_VERTICES : node_reg;
        if (kind == REQ_ADD && a < n && b < n)
        begin
            adj_mirror[a][b] = 1'b1;
            adj_mirror[b][a] = 1'b1;
        end
        else if (kind == REQ_CLEAR)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
                adj_mirror[i] = '0;
        end
        else if (kind == REQ_QUERY)
            pending_results.push_back(max_flow(n, a, b));
    endtask

    // Drain results, settle, then write the node-count register
    task automatic set_nodes(input int value);
        start <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[5:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        node_reg = value[5:0];
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", path_count, -1);
            end
            else
            begin
                flow_result_t want;
                want = pending_results.pop_front();
                if (path_count !== want.count)
                    report_mismatch("path_count", path_count, want.count);
                if (bad_query !== want.bad)
                    report_mismatch("bad_query", bad_query, want.bad);
            end
        end
    end

    task automatic test_directed;
        send_request(REQ_QUERY, 0, 31);
        send_request(REQ_QUERY, 5, 5);
        send_request(REQ_ADD, 0, 1);
        send_request(REQ_ADD, 1, 31);
        send_request(REQ_ADD, 0, 2);
        send_request(REQ_ADD, 2, 31);
        send_request(REQ_ADD, 0, 31);
        send_request(REQ_ADD, 7, 7);
        send_request(REQ_QUERY, 0, 31);
        send_request(REQ_QUERY, 31, 0);
        send_request(REQ_QUERY, 7, 0);
        send_request(2'd3, 0, 31);
        send_request(REQ_CLEAR, 0, 0);
        send_request(REQ_QUERY, 0, 31);
        // node count extremes and out-of-range nodes
        set_nodes(2);
        send_request(REQ_ADD, 0, 1);
        send_request(REQ_ADD, 0, 5);
        send_request(REQ_QUERY, 0, 1);
        send_request(REQ_QUERY, 0, 3);
        set_nodes(1);
        send_request(REQ_QUERY, 0, 1);
        set_nodes(0);
        send_request(REQ_QUERY, 1, 0);
        set_nodes(63);
        send_request(REQ_QUERY, 0, 31);
    endtask

    // Random mix of clears, ignored codes, adds and queries on a given node count
    task automatic test_random(input int nodes, input int items, input int pct);
        int lim;
        idle_pct = pct;
        set_nodes(nodes);
        lim = nodes > MAX_VERTICES ? MAX_VERTICES - 1 : (nodes < 1 ? 0 : nodes - 1);
        for (int k = 0; k < items; k++)
        begin
            int r;
            r = $urandom_range(99, 0);
            if (r < 3)
                send_request(REQ_CLEAR, $urandom, $urandom);
            else if (r < 5)
                send_request(2'd3, $urandom, $urandom);
            else if (r < 60)
                send_request(REQ_ADD, $urandom_range(lim + 1, 0) % 32,
                             $urandom_range(lim, 0));
            else if (r < 95)
                send_request(REQ_QUERY, $urandom_range(lim, 0), $urandom_range(lim, 0));
            else
                send_request(REQ_QUERY, $urandom_range(31, 0), $urandom_range(31, 0));
        end
        idle_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_type = '0;
        node_a = '0;
        node_b = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        error_count = 0;
        idle_pct = 0;
        node_reg = 6'd32;
        for (int i = 0; i < MAX_VERTICES; i++)
            adj_mirror[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(8, 140, 0);
        test_random(32, 140, 45);
        test_random(5, 140, 6);
        test_random(16, 140, 0);
        start <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("tb_edge_disjoint_path_counter_core: PASS");
        else
            $display("tb_edge_disjoint_path_counter_core: FAIL");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("tb_edge_disjoint_path_counter_core: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/edpc_pkg.sv
hdl/edpc_cap_store.sv
hdl/edge_disjoint_path_counter_core.sv
tb/tb_edge_disjoint_path_counter_core.sv
